// ===== rtl/core/mono_bitmap_rotate_to_panel_macros.svh =====
// ----------------------------------------------------------------------------
// mono_bitmap_rotate_to_panel_macros
// Assertion macros used by the canvas rotator datapath.
// ----------------------------------------------------------------------------
`ifndef MONO_BITMAP_ROTATE_TO_PANEL_MACROS_SVH
`define MONO_BITMAP_ROTATE_TO_PANEL_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MBR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define MBR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/mbr_pkg.sv =====
// ----------------------------------------------------------------------------
// mbr_pkg
// Field widths, item kinds and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package mbr_pkg;

  localparam int ROW_W  = 10;
  localparam int COL_W  = 7;
  localparam int DATA_W = 8;
  localparam int BIT_W  = 3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic             load;      // latch the accepted item
    logic             write_go;  // issue the canvas write
    logic             read_go;   // issue one canvas read for a panel bit
    logic [BIT_W-1:0] read_bit;  // panel bit being gathered, 0 is the MSB
    logic             emit;      // move the result into the output register
  } mbr_cmd_t;

  typedef struct packed {
    logic bad;       // latched read lies outside the panel
    logic out_free;  // output register can take a result this cycle
  } mbr_status_t;

endpackage

// ===== rtl/core/mbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbr_ctrl
// Sequencer: accepts an item, issues a write or steps the eight bit reads, hands off result.
// ----------------------------------------------------------------------------
module mbr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_ready,
  input  mbr_pkg::mbr_status_t status,
  output mbr_pkg::mbr_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WRITE  = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // Eight issue steps plus two to drain the read pipeline.
  localparam logic [3:0] STEP_ISSUE_END = 4'd8;
  localparam logic [3:0] STEP_LAST      = 4'd9;

  logic [1:0] state, state_next;
  logic [3:0] step, step_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    cmd.load     = accept;
    cmd.read_bit = step[2:0];
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        if (accept) begin
          state_next = (in_kind == mbr_pkg::KIND_WRITE) ? S_WRITE : S_READ;
        end
      end
      S_WRITE: begin
        cmd.write_go = 1'b1;
        state_next   = S_IDLE;
      end
      S_READ: begin
        if (step == '0 && status.bad) begin
          state_next = S_FINISH;
        end else begin
          cmd.read_go = (step < STEP_ISSUE_END);
          if (step == STEP_LAST) begin
            state_next = S_FINISH;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== rtl/core/mbr_datapath.sv =====
// ----------------------------------------------------------------------------
// mbr_datapath
// Canvas byte store, shared address multiplier, bit gather and output slot.
// ----------------------------------------------------------------------------
`include "mono_bitmap_rotate_to_panel_macros.svh"

module mbr_datapath #(
  parameter int CANVAS_WIDTH  = 540,
  parameter int CANVAS_HEIGHT = 960,
  parameter int CANVAS_PITCH  = 68,
  parameter int PANEL_PITCH   = 120
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mbr_pkg::mbr_cmd_t            cmd,
  output mbr_pkg::mbr_status_t         status,
  input  logic [mbr_pkg::ROW_W-1:0]    in_row,
  input  logic [mbr_pkg::COL_W-1:0]    in_col,
  input  logic [mbr_pkg::DATA_W-1:0]   in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mbr_pkg::DATA_W-1:0]   out_byte,
  output logic                         out_bad
);

  localparam int ROW_W  = mbr_pkg::ROW_W;
  localparam int COL_W  = mbr_pkg::COL_W;
  localparam int DATA_W = mbr_pkg::DATA_W;
  localparam int BIT_W  = mbr_pkg::BIT_W;
  localparam int DEPTH  = CANVAS_HEIGHT * CANVAS_PITCH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MUL_W  = ROW_W + 8;

  logic [DATA_W-1:0] mem [DEPTH];

  // Latched item
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [DATA_W-1:0] data_q;

  // Address generation
  logic [ROW_W-1:0]  x_pos;
  logic [COL_W-1:0]  x_col;
  logic [BIT_W-1:0]  x_bit;
  logic [ROW_W-1:0]  y_pos;
  logic              rd_ok, wr_ok, bad;
  logic [ROW_W-1:0]  mul_row;
  logic [COL_W-1:0]  mul_col;
  logic [MUL_W-1:0]  prod;

  // Access pipeline
  logic              s1_valid, s1_we, s1_ok;
  logic [ADDR_W-1:0] s1_addr;
  logic              s2_valid, s2_ok;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] packed_bits;
  logic              pix;

  assign x_pos = ROW_W'(CANVAS_WIDTH - 1) - row_q;
  assign x_col = x_pos[ROW_W-1:BIT_W];
  assign x_bit = x_pos[BIT_W-1:0];
  assign y_pos = {col_q, {BIT_W{1'b0}}} + ROW_W'(cmd.read_bit);

  assign bad   = ({1'b0, row_q} >= (ROW_W+1)'(CANVAS_WIDTH)) ||
                 ({1'b0, col_q} >= (COL_W+1)'(PANEL_PITCH));
  assign rd_ok = ({1'b0, y_pos} < (ROW_W+1)'(CANVAS_HEIGHT)) &&
                 ({1'b0, x_col} < (COL_W+1)'(CANVAS_PITCH));
  assign wr_ok = ({1'b0, row_q} < (ROW_W+1)'(CANVAS_HEIGHT)) &&
                 ({1'b0, col_q} < (COL_W+1)'(CANVAS_PITCH));

  // One multiplier serves both the write and the read address.
  assign mul_row = cmd.write_go ? row_q : y_pos;
  assign mul_col = cmd.write_go ? col_q : x_col;
  assign prod    = MUL_W'(mul_row) * MUL_W'(CANVAS_PITCH) + MUL_W'(mul_col);

  assign status.bad      = bad;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q  <= in_row;
      col_q  <= in_col;
      data_q <= in_data;
    end
    s1_we   <= cmd.write_go;
    s1_ok   <= cmd.write_go ? wr_ok : rd_ok;
    s1_addr <= prod[ADDR_W-1:0];
    s2_ok   <= s1_ok;
  end

  // Store: one write or one read port access per cycle.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_we && s1_ok) begin
      mem[s1_addr] <= data_q;
    end
    if (s1_valid && !s1_we && s1_ok) begin
      rd_data <= mem[s1_addr];
    end
  end

  // Pixels past the canvas count as clear.
  assign pix = s2_ok && rd_data[(BIT_W)'(DATA_W - 1) - x_bit];

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      packed_bits <= {packed_bits[DATA_W-2:0], pix};
    end
    if (cmd.emit) begin
      out_byte <= bad ? '0 : ~packed_bits;
      out_bad  <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.write_go || cmd.read_go;
      s2_valid <= s1_valid && !s1_we;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MBR_ASSERT_NEXT(a_read_reaches_gather, cmd.read_go, s2_valid == 1'b0 || s1_valid, "read step lost in pipeline")
  `MBR_ASSERT_NOW(a_write_not_mixed, s1_valid && s1_we, !s2_valid, "write overlaps a read in flight")
  `MBR_ASSERT_NOW(a_bad_reads_zero, out_valid && out_bad, out_byte == '0, "bad address result not zero")

endmodule

// ===== rtl/core/mono_bitmap_rotate_to_panel.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_rotate_to_panel
// One-bit-per-pixel portrait canvas store read back rotated 90 degrees and
// inverted, one panel byte per read item.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload (low bit first)
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | tdata: row_index, byte_column, data; tuser: kind
//  m_axis   | out       | tdata: panel_byte; tuser: bad_address
//
// A write item gives no result.
// A read item inside the panel makes eight single-byte reads of the canvas
// store through its one port, through address and read-data stages.
// A read outside the panel makes no store reads and returns zero with bad_address.
// Reset clears control only; the store holds garbage until written, no sweep.
// A stalled output holds its result; the next item is still taken meanwhile.
// ----------------------------------------------------------------------------
module mono_bitmap_rotate_to_panel #(
  parameter int CANVAS_WIDTH  = 540,
  parameter int CANVAS_HEIGHT = 960,
  parameter int CANVAS_PITCH  = 68,
  parameter int PANEL_PITCH   = 120
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // row_index[9:0], byte_column[16:10], data[24:17]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // panel_byte[7:0]
  output logic        m_axis_tuser    // bad_address
);

  localparam int ROW_W  = mbr_pkg::ROW_W;
  localparam int COL_W  = mbr_pkg::COL_W;
  localparam int DATA_W = mbr_pkg::DATA_W;

  mbr_pkg::mbr_cmd_t    cmd;
  mbr_pkg::mbr_status_t status;

  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  byte_column;
  logic [DATA_W-1:0] data;

  // Unpack the item; upper tdata bits are padding.
  assign row_index   = s_axis_tdata[ROW_W-1:0];
  assign byte_column = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign data        = s_axis_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];

  // Sequencer: one item at a time through the store.
  mbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, address math, bit gather and output register.
  mbr_datapath #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT),
    .CANVAS_PITCH  (CANVAS_PITCH),
    .PANEL_PITCH   (PANEL_PITCH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_row    (row_index),
    .in_col    (byte_column),
    .in_data   (data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_bad   (m_axis_tuser)
  );

endmodule
